@@ rtl/m3ed_pkg.sv @@
package m3ed_pkg;

	localparam int PIX_W      = 8;
	localparam int DIM_W      = 11;
	localparam int WIN_N      = 9;
	localparam int APB_AW     = 4;
	localparam int APB_DW     = 32;
	localparam int DIM_MIN    = 3;
	localparam int WIDTH_RST  = 720;
	localparam int HEIGHT_RST = 576;

	localparam logic [PIX_W-1:0] PIX_ONES = 8'd255;

	typedef enum logic [1:0] {
		REG_MODE   = 2'd0,
		REG_WIDTH  = 2'd1,
		REG_HEIGHT = 2'd2
	} reg_idx_t;

	typedef enum logic {
		MODE_ERODE  = 1'b0,
		MODE_DILATE = 1'b1
	} mode_t;

	typedef struct packed {
		mode_t            mode;
		logic [DIM_W-1:0] width;
		logic [DIM_W-1:0] height;
		logic             restart;
	} cfg_t;

	typedef struct packed {
		logic emit;
		logic eol;
		logic done;
		logic ok_r0;
		logic ok_r2;
		logic ok_c0;
		logic ok_c2;
	} win_ctrl_t;

endpackage

@@ rtl/m3ed_in_if.sv @@
interface m3ed_in_if;
	logic                      valid;
	logic                      ready;
	logic                      operation;
	logic [m3ed_pkg::PIX_W-1:0] pixel_in;

	modport source (output valid, output operation, output pixel_in, input ready);
	modport sink (input valid, input operation, input pixel_in, output ready);
endinterface

@@ rtl/m3ed_out_if.sv @@
interface m3ed_out_if;
	logic                      valid;
	logic                      ready;
	logic [m3ed_pkg::PIX_W-1:0] pixel_out;
	logic                      frame_done;

	modport source (output valid, output pixel_out, output frame_done, input ready);
	modport sink (input valid, input pixel_out, input frame_done, output ready);
endinterface

@@ rtl/morph_3x3_erode_dilate_core.sv @@
// 3x3 erosion/dilation on a raster stream of 8-bit pixels. One transaction is taken every
// cycle unless stalled; inputs are registered in s1, results in the output register. In
// raster terms each result lags its input by one line plus one pixel, so after the last
// pixel of a frame the source sends width+1 flush transactions (operation=1). The rate
// is set by the line store, a single 16-bit wide memory of MAX_WIDTH entries holding the
// two previous lines: every pixel reads its column when accepted and writes it back from
// s1, with a bypass when the write meets the following read. Erosion gives 0 on the frame
// border; dilation treats pixels outside the frame as 0. Registers at byte offset 0
// (mode), 4 (frame_width) and 8 (frame_height); width and height saturate to 3..MAX and
// a write to either restarts the frame. Configure only while the stream is idle.
module morph_3x3_erode_dilate_core #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	m3ed_in_if.sink                       pix_in,
	m3ed_out_if.source                    pix_out,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [m3ed_pkg::APB_AW-1:0]   paddr,
	input  logic [m3ed_pkg::APB_DW-1:0]   pwdata,
	output logic [m3ed_pkg::APB_DW-1:0]   prdata,
	output logic                          pready
);

	localparam int AW = $clog2(MAX_WIDTH);

	m3ed_pkg::cfg_t                 cfg;
	m3ed_pkg::win_ctrl_t            ctrl;
	logic [AW-1:0]                  col, wr_addr;
	logic [2*m3ed_pkg::PIX_W-1:0]   rd_data, wr_data;
	logic [m3ed_pkg::PIX_W-1:0]     value;
	logic                           accept, blocked, wr_en;

	assign pix_in.ready = !blocked;
	assign accept       = pix_in.valid && !blocked;
	assign value        = pix_in.operation ? '0 : pix_in.pixel_in;

	m3ed_regs #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	m3ed_seq #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.accept (accept),
		.col    (col),
		.ctrl   (ctrl)
	);

	m3ed_line_mem #(
		.DEPTH (MAX_WIDTH)
	) u_line_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (col),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_data (rd_data)
	);

	m3ed_window #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.accept  (accept),
		.ctrl    (ctrl),
		.value   (value),
		.addr    (col),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.blocked (blocked),
		.pix_out (pix_out)
	);

endmodule

@@ rtl/m3ed_regs.sv @@
module m3ed_regs #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [m3ed_pkg::APB_AW-1:0]   paddr,
	input  logic [m3ed_pkg::APB_DW-1:0]   pwdata,
	output logic [m3ed_pkg::APB_DW-1:0]   prdata,
	output logic                          pready,
	output m3ed_pkg::cfg_t                cfg
);

	localparam int W_RST = (MAX_WIDTH < m3ed_pkg::WIDTH_RST) ? MAX_WIDTH : m3ed_pkg::WIDTH_RST;
	localparam int H_RST = (MAX_HEIGHT < m3ed_pkg::HEIGHT_RST) ? MAX_HEIGHT :
		m3ed_pkg::HEIGHT_RST;

	function automatic logic [m3ed_pkg::DIM_W-1:0] clamp_dim(
		input logic [m3ed_pkg::DIM_W-1:0] v,
		input int                         maxv
	);
		logic [m3ed_pkg::DIM_W-1:0] r;
		if (32'(v) < m3ed_pkg::DIM_MIN) begin
			r = m3ed_pkg::DIM_W'(m3ed_pkg::DIM_MIN);
		end else if (32'(v) > maxv) begin
			r = m3ed_pkg::DIM_W'(maxv);
		end else begin
			r = v;
		end
		return r;
	endfunction

	m3ed_pkg::mode_t              mode_q;
	logic [m3ed_pkg::DIM_W-1:0]   width_q;
	logic [m3ed_pkg::DIM_W-1:0]   height_q;
	logic                         wr;
	m3ed_pkg::reg_idx_t           idx;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign idx    = m3ed_pkg::reg_idx_t'(paddr[m3ed_pkg::APB_AW-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= m3ed_pkg::MODE_ERODE;
			width_q  <= m3ed_pkg::DIM_W'(W_RST);
			height_q <= m3ed_pkg::DIM_W'(H_RST);
		end else if (wr) begin
			unique case (idx)
				m3ed_pkg::REG_MODE: begin
					mode_q <= m3ed_pkg::mode_t'(pwdata[0]);
				end
				m3ed_pkg::REG_WIDTH: begin
					width_q <= clamp_dim(pwdata[m3ed_pkg::DIM_W-1:0], MAX_WIDTH);
				end
				m3ed_pkg::REG_HEIGHT: begin
					height_q <= clamp_dim(pwdata[m3ed_pkg::DIM_W-1:0], MAX_HEIGHT);
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			m3ed_pkg::REG_MODE:   prdata = m3ed_pkg::APB_DW'(mode_q);
			m3ed_pkg::REG_WIDTH:  prdata = m3ed_pkg::APB_DW'(width_q);
			m3ed_pkg::REG_HEIGHT: prdata = m3ed_pkg::APB_DW'(height_q);
			default:              prdata = '0;
		endcase
	end

	always_comb begin
		cfg.mode    = mode_q;
		cfg.width   = width_q;
		cfg.height  = height_q;
		cfg.restart = wr && ((idx == m3ed_pkg::REG_WIDTH) || (idx == m3ed_pkg::REG_HEIGHT));
	end

endmodule

@@ rtl/m3ed_seq.sv @@
module m3ed_seq #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  m3ed_pkg::cfg_t                cfg,
	input  logic                          accept,
	output logic [$clog2(MAX_WIDTH)-1:0]  col,
	output m3ed_pkg::win_ctrl_t           ctrl
);

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT + 3);

	logic [AW-1:0] col_q;
	logic [RW-1:0] row_q;
	int            ri, ci, w, h, cr, cc, ri_nxt, ci_nxt;
	logic          eol, mid;

	assign col = col_q;

	always_comb begin
		ri  = 32'(row_q);
		ci  = 32'(col_q);
		w   = 32'(cfg.width);
		h   = 32'(cfg.height);
		eol = (ci == 0) && (ri >= 2);
		mid = (ci >= 1) && (ri >= 1) && (ri - 1 < h);
		cr  = eol ? ri - 2 : ri - 1;
		cc  = eol ? w - 1 : ci - 1;

		ctrl.emit  = eol || mid;
		ctrl.eol   = eol;
		ctrl.done  = (eol || mid) && (cr + 1 == h) && (cc + 1 == w);
		ctrl.ok_r0 = cr > 0;
		ctrl.ok_r2 = cr + 1 < h;
		ctrl.ok_c0 = cc > 0;
		ctrl.ok_c2 = cc + 1 < w;

		ci_nxt = ci + 1;
		ri_nxt = ri;
		if (ci_nxt >= w) begin
			ci_nxt = 0;
			ri_nxt = ri + 1;
		end
		if (ri_nxt > h + 1 || ctrl.done) begin
			ci_nxt = 0;
			ri_nxt = 0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg.restart) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			col_q <= AW'(ci_nxt);
			row_q <= RW'(ri_nxt);
		end
	end

endmodule

@@ rtl/m3ed_line_mem.sv @@
module m3ed_line_mem #(
	parameter int DEPTH = 1024
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            rd_en,
	input  logic [$clog2(DEPTH)-1:0]        rd_addr,
	input  logic                            wr_en,
	input  logic [$clog2(DEPTH)-1:0]        wr_addr,
	input  logic [2*m3ed_pkg::PIX_W-1:0]    wr_data,
	output logic [2*m3ed_pkg::PIX_W-1:0]    rd_data
);

	logic [2*m3ed_pkg::PIX_W-1:0] mem [DEPTH];
	logic [2*m3ed_pkg::PIX_W-1:0] rdata_q;
	logic [2*m3ed_pkg::PIX_W-1:0] fwd_data_q;
	logic                         fwd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q    <= mem[rd_addr];
			fwd_data_q <= wr_data;
		end
	end

	// bypass a write that lands on the entry being read in the same cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (rd_en) begin
			fwd_q <= wr_en && (wr_addr == rd_addr);
		end
	end

	assign rd_data = fwd_q ? fwd_data_q : rdata_q;

endmodule

@@ rtl/m3ed_window.sv @@
module m3ed_window #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  m3ed_pkg::cfg_t                  cfg,
	input  logic                            accept,
	input  m3ed_pkg::win_ctrl_t             ctrl,
	input  logic [m3ed_pkg::PIX_W-1:0]      value,
	input  logic [$clog2(MAX_WIDTH)-1:0]    addr,
	input  logic [2*m3ed_pkg::PIX_W-1:0]    rd_data,
	output logic                            wr_en,
	output logic [$clog2(MAX_WIDTH)-1:0]    wr_addr,
	output logic [2*m3ed_pkg::PIX_W-1:0]    wr_data,
	output logic                            blocked,
	m3ed_out_if.source                      pix_out
);

	localparam int AW = $clog2(MAX_WIDTH);

	logic                          valid_s1;
	m3ed_pkg::win_ctrl_t           ctrl_s1;
	logic [m3ed_pkg::PIX_W-1:0]    value_s1;
	logic [AW-1:0]                 addr_s1;
	logic [m3ed_pkg::PIX_W-1:0]    win_q [m3ed_pkg::WIN_N];
	logic [m3ed_pkg::PIX_W-1:0]    win_nxt [m3ed_pkg::WIN_N];
	logic [m3ed_pkg::PIX_W-1:0]    op_win [m3ed_pkg::WIN_N];
	logic                          out_valid_q;
	logic [m3ed_pkg::PIX_W-1:0]    out_pix_q;
	logic                          out_done_q;
	logic [m3ed_pkg::PIX_W-1:0]    line_a, line_b, and_acc, or_acc, result;
	logic [2:0]                    ok_row, ok_col;
	logic                          advance, emit;

	assign blocked = valid_s1 && ctrl_s1.emit && out_valid_q && !pix_out.ready;
	assign advance = !blocked;
	assign emit    = advance && valid_s1 && ctrl_s1.emit;
	assign wr_en   = advance && valid_s1;
	assign wr_addr = addr_s1;
	assign wr_data = {line_a, value_s1};

	assign pix_out.valid      = out_valid_q;
	assign pix_out.pixel_out  = out_pix_q;
	assign pix_out.frame_done = out_done_q;

	always_comb begin
		line_b = rd_data[2*m3ed_pkg::PIX_W-1:m3ed_pkg::PIX_W];
		line_a = rd_data[m3ed_pkg::PIX_W-1:0];
		for (int k = 0; k < 3; k++) begin
			win_nxt[k*3]   = win_q[k*3+1];
			win_nxt[k*3+1] = win_q[k*3+2];
			op_win[k*3]    = win_q[k*3+1];
			op_win[k*3+1]  = win_q[k*3+2];
			op_win[k*3+2]  = '0;
		end
		win_nxt[2] = line_b;
		win_nxt[5] = line_a;
		win_nxt[8] = value_s1;
		if (!ctrl_s1.eol) begin
			op_win = win_nxt;
		end

		ok_row  = {ctrl_s1.ok_r2, 1'b1, ctrl_s1.ok_r0};
		ok_col  = {ctrl_s1.ok_c2, 1'b1, ctrl_s1.ok_c0};
		and_acc = m3ed_pkg::PIX_ONES;
		or_acc  = '0;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				and_acc = and_acc & op_win[i*3+j];
				if (ok_row[i] && ok_col[j]) begin
					or_acc = or_acc | op_win[i*3+j];
				end
			end
		end

		priority if (cfg.mode == m3ed_pkg::MODE_DILATE) begin
			result = or_acc;
		end else if (&{ok_row, ok_col}) begin
			result = and_acc;
		end else begin
			result = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				valid_s1 <= accept;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (pix_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < m3ed_pkg::WIN_N; k++) begin
				win_q[k] <= '0;
			end
		end else if (cfg.restart) begin
			for (int k = 0; k < m3ed_pkg::WIN_N; k++) begin
				win_q[k] <= '0;
			end
		end else if (wr_en) begin
			win_q <= win_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ctrl_s1  <= ctrl;
			value_s1 <= value;
			addr_s1  <= addr;
		end
		if (emit) begin
			out_pix_q  <= result;
			out_done_q <= ctrl_s1.done;
		end
	end

endmodule

@@ tb/m3ed_window_checker.sv @@
module m3ed_window_checker #(
	parameter int MAX_W = 1024,
	parameter int MAX_H = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	m3ed_in_if                          pix_in,
	m3ed_out_if                         pix_out,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic                        pready,
	input  logic [m3ed_pkg::APB_AW-1:0] paddr,
	input  logic [m3ed_pkg::APB_DW-1:0] pwdata,
	output int                          fail_count,
	output int                          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import m3ed_pkg::*;

	localparam logic OP_FLUSH = 1'b1;
	localparam int   MAX_REPORTS = 10;

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic             frame_done;
	} filt_px_t;

	logic [PIX_W-1:0]        line_above [MAX_W];
	logic [PIX_W-1:0]        line_two_up [MAX_W];
	logic [8:0][PIX_W-1:0]   win;
	int                      col;
	int                      row;
	mode_t                   mode_r;
	int                      width_r;
	int                      height_r;
	int                      mismatches;
	int                      results_seen;
	filt_px_t                expected_px_q[$];

	function automatic int clamp_dim(input logic [DIM_W-1:0] v, input int maxv);
		if (v < DIM_MIN)
			return DIM_MIN;
		if (v > maxv)
			return maxv;
		return int'(v);
	endfunction

	function automatic logic [PIX_W-1:0] window_result(input logic [8:0][PIX_W-1:0] w,
			input int cr, input int cc);
		logic [2:0]       row_ok;
		logic [2:0]       col_ok;
		logic [PIX_W-1:0] acc;
		row_ok = {cr + 1 < height_r, 1'b1, cr > 0};
		col_ok = {cc + 1 < width_r, 1'b1, cc > 0};
		if (mode_r == MODE_ERODE) begin
			if (!(&row_ok && &col_ok))
				return '0;
			acc = PIX_ONES;
			for (int i = 0; i < 9; i++)
				acc &= w[i];
			return acc;
		end
		acc = '0;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				if (row_ok[i] && col_ok[j])
					acc |= w[i * 3 + j];
		return acc;
	endfunction

	task automatic restart_frame();
		col = 0;
		row = 0;
		win = '0;
	endtask

	task automatic filter_step(input logic op, input logic [PIX_W-1:0] pix);
		int                    ri;
		int                    ci;
		int                    cr;
		int                    cc;
		logic [PIX_W-1:0]      value;
		logic [8:0][PIX_W-1:0] shifted;
		filt_px_t              res;
		bit                    has;
		ri = row;
		ci = col;
		cr = 0;
		cc = 0;
		has = 0;
		res = '0;
		value = (op == OP_FLUSH) ? '0 : pix;
		// centre on the last column of the row two up
		if (ci == 0 && ri >= 2) begin
			for (int k = 0; k < 3; k++) begin
				shifted[k * 3] = win[k * 3 + 1];
				shifted[k * 3 + 1] = win[k * 3 + 2];
				shifted[k * 3 + 2] = '0;
			end
			cr = ri - 2;
			cc = width_r - 1;
			res.pixel = window_result(shifted, cr, cc);
			has = 1;
		end
		if (ci < MAX_W) begin
			for (int k = 0; k < 3; k++) begin
				win[k * 3] = win[k * 3 + 1];
				win[k * 3 + 1] = win[k * 3 + 2];
			end
			win[2] = line_two_up[ci];
			win[5] = line_above[ci];
			win[8] = value;
			line_two_up[ci] = line_above[ci];
			line_above[ci] = value;
		end
		if (ci >= 1 && ri >= 1 && ri - 1 < height_r) begin
			cr = ri - 1;
			cc = ci - 1;
			res.pixel = window_result(win, cr, cc);
			has = 1;
		end
		if (has) begin
			res.frame_done = (cr + 1 == height_r) && (cc + 1 == width_r);
			expected_px_q.push_back(res);
		end
		if (has && res.frame_done) begin
			row = 0;
			col = 0;
		end else begin
			ci++;
			if (ci >= width_r) begin
				ci = 0;
				ri++;
			end
			if (ri > height_r + 1) begin
				ri = 0;
				ci = 0;
			end
			row = ri;
			col = ci;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_W; i++) begin
				line_above[i] = '0;
				line_two_up[i] = '0;
			end
			mode_r = MODE_ERODE;
			width_r = clamp_dim(DIM_W'(WIDTH_RST), MAX_W);
			height_r = clamp_dim(DIM_W'(HEIGHT_RST), MAX_H);
			restart_frame();
			expected_px_q.delete();
			mismatches = 0;
			results_seen = 0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[APB_AW-1:2])
					REG_MODE: mode_r = mode_t'(pwdata[0]);
					REG_WIDTH: begin
						width_r = clamp_dim(pwdata[DIM_W-1:0], MAX_W);
						restart_frame();
					end
					REG_HEIGHT: begin
						height_r = clamp_dim(pwdata[DIM_W-1:0], MAX_H);
						restart_frame();
					end
					default: ;
				endcase
			end
			if (pix_in.valid && pix_in.ready)
				filter_step(pix_in.operation, pix_in.pixel_in);
			if (pix_out.valid && pix_out.ready) begin
				if (expected_px_q.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("result %0d: unexpected transaction pixel_out=%0d frame_done=%0b",
							results_seen, pix_out.pixel_out, pix_out.frame_done);
				end else begin
					filt_px_t exp_px;
					exp_px = expected_px_q.pop_front();
					if (pix_out.pixel_out !== exp_px.pixel ||
							pix_out.frame_done !== exp_px.frame_done) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display("result %0d: pixel_out exp %0d got %0d, frame_done exp %0b got %0b",
								results_seen, exp_px.pixel, pix_out.pixel_out,
								exp_px.frame_done, pix_out.frame_done);
					end
				end
				results_seen++;
			end
			fail_count <= mismatches;
			pending <= expected_px_q.size();
		end
	end

endmodule

@@ tb/testbench.sv @@
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import m3ed_pkg::*;

	localparam int         MAX_W = 1024;
	localparam int         MAX_H = 1024;
	localparam logic       OP_PIXEL = 1'b0;
	localparam logic       OP_FLUSH = 1'b1;
	localparam logic [1:0] REG_SPARE = 2'd3;
	localparam int         SETTLE_CYCLES = 8;
	localparam int         HOLD_CYCLES = 400;
	localparam int         STALL_LIMIT = 4000;
	localparam int         RANDOM_ITEMS = 1100;
	localparam int         CALM_ITEMS = 150;
	localparam int         SHORT_ITEMS = 40;

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [APB_AW-1:0]   paddr;
	logic [APB_DW-1:0]   pwdata;
	logic [APB_DW-1:0]   prdata;
	logic                pready;
	int                  fail_count;
	int                  pending;
	bit                  gaps_on;
	bit                  hold_req;
	int                  random_sent;
	int                  idle_cycles;

	m3ed_in_if  pix_in_ch ();
	m3ed_out_if pix_out_ch ();

	morph_3x3_erode_dilate_core #(
		.MAX_WIDTH (MAX_W),
		.MAX_HEIGHT(MAX_H)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pix_in (pix_in_ch),
		.pix_out(pix_out_ch),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready)
	);

	m3ed_window_checker #(
		.MAX_W(MAX_W),
		.MAX_H(MAX_H)
	) i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_in    (pix_in_ch),
		.pix_out   (pix_out_ch),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.pready    (pready),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.fail_count(fail_count),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		if (!arst_n || (pix_in_ch.valid && pix_in_ch.ready) ||
				(pix_out_ch.valid && pix_out_ch.ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles == STALL_LIMIT) begin
				$display("morph_3x3_erode_dilate_core test failed");
				$finish;
			end
		end
	end

	initial begin
		pix_out_ch.ready <= 1'b0;
		wait (arst_n);
		forever begin
			if (hold_req) begin
				pix_out_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 0;
			end else if (gaps_on && $urandom_range(0, 5) == 0) begin
				pix_out_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end else begin
				pix_out_ch.ready <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [APB_DW-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_item(input logic op, input logic [PIX_W-1:0] pix);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			pix_in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		pix_in_ch.valid <= 1'b1;
		pix_in_ch.operation <= op;
		pix_in_ch.pixel_in <= pix;
		do @(posedge clk); while (!pix_in_ch.ready);
	endtask

	// drop valid, drain all results, then let trailing items settle
	task automatic drain();
		pix_in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [PIX_W-1:0] rand_pixel();
		case ($urandom_range(0, 3))
			0: return PIX_W'($urandom);
			1: return PIX_ONES;
			2: return '0;
			default: return PIX_ONES ^ (PIX_W'(1) << $urandom_range(0, PIX_W - 1));
		endcase
	endfunction

	task automatic set_size(input mode_t m, input int w, input int h);
		write_reg(REG_MODE, {$urandom} & ~APB_DW'(1) | APB_DW'(m));
		write_reg(REG_WIDTH, {21'($urandom), 11'(w)});
		write_reg(REG_HEIGHT, {21'($urandom), 11'(h)});
	endtask

	task automatic send_frame(input int w, input int h, input int cut);
		int n;
		n = w * h;
		for (int i = 0; i < n + w + 1 && i < cut; i++) begin
			if (i < n)
				send_item(($urandom_range(0, 15) == 0) ? OP_FLUSH : OP_PIXEL, rand_pixel());
			else
				send_item(($urandom_range(0, 3) == 0) ? OP_PIXEL : OP_FLUSH, rand_pixel());
		end
	endtask

	initial begin
		int    w;
		int    h;
		int    frames;
		int    cut;
		int    phase;
		mode_t m;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		pix_in_ch.valid <= 1'b0;
		pix_in_ch.operation <= OP_PIXEL;
		pix_in_ch.pixel_in <= '0;
		gaps_on = 1;
		hold_req = 0;
		random_sent = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		repeat (6) send_item(OP_PIXEL, rand_pixel());
		drain();

		write_reg(REG_MODE, APB_DW'(MODE_ERODE));
		write_reg(REG_WIDTH, APB_DW'(DIM_MIN));
		write_reg(REG_HEIGHT, APB_DW'(DIM_MIN));
		write_reg(REG_SPARE, '1);
		repeat (9) send_item(OP_PIXEL, PIX_ONES);
		repeat (4) send_item(OP_FLUSH, PIX_ONES);
		drain();

		write_reg(REG_MODE, APB_DW'(MODE_DILATE));
		send_item(OP_PIXEL, 8'h80);
		send_item(OP_PIXEL, 8'h00);
		send_item(OP_PIXEL, 8'h01);
		send_item(OP_PIXEL, 8'h00);
		send_item(OP_FLUSH, PIX_ONES);
		send_item(OP_PIXEL, 8'h10);
		send_item(OP_PIXEL, 8'h02);
		send_item(OP_PIXEL, 8'h00);
		send_item(OP_PIXEL, 8'h40);
		send_item(OP_FLUSH, 8'h00);
		send_item(OP_PIXEL, 8'hA5);
		repeat (2) send_item(OP_FLUSH, 8'h5A);
		drain();

		phase = 0;
		while (random_sent < RANDOM_ITEMS) begin
			m = mode_t'($urandom_range(0, 1));
			if (phase == 2) begin
				// widest line: width saturates down, height saturates up
				set_size(m, 2047, 1);
				send_frame(MAX_W, DIM_MIN, SHORT_ITEMS);
				random_sent += SHORT_ITEMS;
			end else if (phase == 4) begin
				set_size(m, 0, 2047);
				send_frame(DIM_MIN, MAX_H, SHORT_ITEMS);
				random_sent += SHORT_ITEMS;
			end else begin
				if (phase == 0) begin
					w = 16;
					h = 12;
				end else if (phase == 6) begin
					w = DIM_MIN;
					h = DIM_MIN;
				end else begin
					w = $urandom_range(3, 12);
					h = $urandom_range(3, 8);
				end
				set_size(m, w, h);
				if (phase == 0)
					hold_req = 1;
				frames = $urandom_range(1, 3);
				for (int f = 0; f < frames; f++) begin
					cut = ($urandom_range(0, 7) == 0) ? $urandom_range(1, w * h + w) : w * h + w + 1;
					send_frame(w, h, cut);
					random_sent += cut;
					if (random_sent > RANDOM_ITEMS - CALM_ITEMS)
						gaps_on = 0;
				end
			end
			drain();
			phase++;
		end

		drain();
		if (fail_count == 0 && pending == 0)
			$display("morph_3x3_erode_dilate_core test passed");
		else
			$display("morph_3x3_erode_dilate_core test failed");
		$finish;
	end

endmodule
